### src/wpm_pkg.sv
// wildcard pattern matcher: shared types, constants and codes
// used by wpm_cell, wpm_star_close and wildcard_pattern_matcher; no dependencies
package wpm_pkg;

  localparam int unsigned MAX_PATTERN = 128;
  localparam int unsigned POS_N       = MAX_PATTERN + 1;
  localparam int unsigned LEN_W       = $clog2(MAX_PATTERN + 1);

  typedef logic [7:0]       sym_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [1:0]       mode_t;
  typedef logic [POS_N-1:0] pos_vec_t;

  localparam sym_t STAR_CODE = 8'h2A;
  localparam sym_t ANY_CODE  = 8'h3F;

  localparam mode_t MODE_PATTERN = 2'd0;
  localparam mode_t MODE_CHAR    = 2'd1;
  localparam mode_t MODE_END     = 2'd2;

  // per-cell control from the top level
  typedef struct packed {
    logic wr;        // store the symbol in this cell
    logic clear;     // pattern restarts, cell drops out unless written
    logic reach_en;  // take the closed reach bit
  } cell_ctrl_t;

  // per-cell status towards the top level
  typedef struct packed {
    logic act;       // cell holds a pattern character
    logic reach;     // position is reachable
    logic star_nx;   // cell will hold a star after this cycle
    logic fwd;       // word character steps past this position
    logic stay;      // star absorbs the word character
  } cell_stat_t;

endpackage

### src/wpm_cell.sv
// wildcard pattern matcher: one pattern position (character, flags, reach bit)
// depends on wpm_pkg
module wpm_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              reach_init_i,
  input  wpm_pkg::cell_ctrl_t ctrl_i,
  input  wpm_pkg::sym_t     sym_i,
  input  logic              reach_i,
  output wpm_pkg::cell_stat_t stat_o
);

  wpm_pkg::sym_t char_q;
  logic          star_q, any_q;
  logic          act_q, act_d;
  logic          reach_q;
  logic          star_d;
  logic          hit;

  assign act_d  = ctrl_i.wr | (act_q & ~ctrl_i.clear);
  assign star_d = ctrl_i.wr ? (sym_i == wpm_pkg::STAR_CODE) : star_q;
  assign hit    = any_q | (char_q == sym_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      char_q <= sym_i;
      star_q <= (sym_i == wpm_pkg::STAR_CODE);
      any_q  <= (sym_i == wpm_pkg::ANY_CODE);
    end
  end

  // position zero comes out of reset reachable, all others not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      reach_q <= reach_init_i;
    end else begin
      act_q <= act_d;
      if (ctrl_i.reach_en) begin
        reach_q <= reach_i;
      end
    end
  end

  assign stat_o.act     = act_q;
  assign stat_o.reach   = reach_q;
  assign stat_o.star_nx = act_d & star_d;
  assign stat_o.fwd     = act_q & reach_q & ~star_q & hit;
  assign stat_o.stay    = act_q & reach_q & star_q;

endmodule

### src/wpm_star_close.sv
// wildcard pattern matcher: closes a reach vector over runs of stars
// carry chain: a star propagates reach, a reachable star generates it; uses wpm_pkg
module wpm_star_close (
  input  wpm_pkg::pos_vec_t base_i,
  input  wpm_pkg::pos_vec_t star_i,
  output wpm_pkg::pos_vec_t reach_o
);

  wpm_pkg::pos_vec_t gen, sum, carry;

  assign gen     = base_i & star_i;
  assign sum     = gen + star_i;
  // carry into each bit: position reached through a star just below it
  assign carry   = sum ^ gen ^ star_i;
  assign reach_o = base_i | carry;

endmodule

### src/wildcard_pattern_matcher.sv
// wildcard pattern matcher top level: row of position cells, star closure, result register
// depends on wpm_pkg, wpm_cell and wpm_star_close
//
// Matches words against a glob pattern where '?' takes any one byte and '*' any run of
// bytes, including none; any other byte matches only itself, and in a word '*' and '?'
// are plain bytes. Load the pattern with mode 0 items (first_of_pattern set on its first
// character), send a word as mode 1 items and end it with a mode 2 item, which gives one
// result: matched, plus pattern_overflow when characters beyond 128 were dropped. Mode 3
// items are taken and ignored. Items may follow back to back; the result of a word end sits
// in the output register the cycle after the transfer and the input stalls only while that
// register is full and not being taken. Each pattern position is a cell holding its
// character and reach bit, all cells step together; the cycle is set by the star-closure
// carry chain running across all 129 positions. A new pattern character, like a word end,
// abandons any word in progress. No clearing pass is needed after reset.
module wildcard_pattern_matcher (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          symbol_i,
  input  logic                first_of_pattern_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                matched_o,
  output logic                pattern_overflow_o
);

  localparam int unsigned MaxPat = wpm_pkg::MAX_PATTERN;

  // control and pattern bookkeeping
  wpm_pkg::len_t      len_q, len_d;
  wpm_pkg::len_t      wr_idx;
  logic               ovf_q, ovf_d;
  logic               reach_end_q;
  logic               out_valid_q, matched_q, out_ovf_q;

  logic               in_xfer;
  logic               do_load, do_char, do_end;
  logic               room;

  wpm_pkg::cell_ctrl_t cell_ctrl [MaxPat];
  wpm_pkg::cell_stat_t cell_stat [MaxPat];
  logic [MaxPat-1:0]   cell_act, cell_reach, cell_star, cell_fwd, cell_stay;

  wpm_pkg::pos_vec_t  base_vec, star_vec, closed_vec, reach_all;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_xfer    = in_valid_i & in_ready_o;

  always_comb begin
    do_load = 1'b0;
    do_char = 1'b0;
    do_end  = 1'b0;
    unique case (mode_i)
      wpm_pkg::MODE_PATTERN: do_load = in_xfer;
      wpm_pkg::MODE_CHAR:    do_char = in_xfer;
      wpm_pkg::MODE_END:     do_end  = in_xfer;
      default: ;  // unused mode, item dropped
    endcase
  end

  // a pattern restart always has room; otherwise append while not full
  assign room   = first_of_pattern_i | (len_q < wpm_pkg::len_t'(MaxPat));
  assign wr_idx = first_of_pattern_i ? '0 : len_q;

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (do_load) begin
      if (first_of_pattern_i) begin
        len_d = wpm_pkg::len_t'(1);
        ovf_d = 1'b0;
      end else if (room) begin
        len_d = len_q + wpm_pkg::len_t'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // row of position cells
  for (genvar i = 0; i < MaxPat; i++) begin : g_cell
    assign cell_ctrl[i].wr       = do_load & room & (wr_idx == wpm_pkg::len_t'(i));
    assign cell_ctrl[i].clear    = do_load & first_of_pattern_i;
    assign cell_ctrl[i].reach_en = do_load | do_char | do_end;

    wpm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .reach_init_i (i == 0),
      .ctrl_i       (cell_ctrl[i]),
      .sym_i        (symbol_i),
      .reach_i      (closed_vec[i]),
      .stat_o       (cell_stat[i])
    );

    assign cell_act[i]   = cell_stat[i].act;
    assign cell_reach[i] = cell_stat[i].reach;
    assign cell_star[i]  = cell_stat[i].star_nx;
    assign cell_fwd[i]   = cell_stat[i].fwd;
    assign cell_stay[i]  = cell_stat[i].stay;
  end

  // reach before closure: restart puts only position zero, a word character takes each
  // reachable cell one step on or keeps it on a star
  always_comb begin
    if (do_char) begin
      base_vec = {1'b0, cell_stay} | {cell_fwd, 1'b0};
    end else begin
      base_vec = wpm_pkg::pos_vec_t'(1);
    end
  end

  // the end position never holds a star
  assign star_vec = {1'b0, cell_star};

  wpm_star_close u_close (
    .base_i  (base_vec),
    .star_i  (star_vec),
    .reach_o (closed_vec)
  );

  assign reach_all = {reach_end_q, cell_reach};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      reach_end_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
      if (do_load | do_char | do_end) begin
        reach_end_q <= closed_vec[MaxPat];
      end
      if (do_end) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded on the word end transfer
  always_ff @(posedge clk_i) begin
    if (do_end) begin
      matched_q <= reach_all[len_q];
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = out_ovf_q;

  // checks on the position row and bookkeeping

  // filled cells form a prefix whose size is the pattern length
  a_act_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_act) == int'(len_q))
    else $error("filled cells disagree with pattern length");

  // no position beyond the end of the pattern is ever reachable
  a_reach_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (reach_all[MaxPat:1] & ~cell_act) == '0)
    else $error("reach set beyond pattern end");

  // dropped characters only once the pattern is full
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (len_q == wpm_pkg::len_t'(MaxPat)))
    else $error("overflow flagged while pattern not full");

  // every word end produces a result the next cycle
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_end |=> out_valid_q)
    else $error("word end without result");

endmodule
